// File: rtl/core/pehp_pkg.sv
// pehp_pkg: shared types, codes and keyword tables for the pax extended header parser
// no dependencies
`default_nettype none
package pehp_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int NKEYS           = 10;
    localparam int KEY_IDX_BITS    = 4;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_LEN        = 3'd0,
        PH_KEY        = 3'd1,
        PH_NUM_LEAD   = 3'd2,
        PH_NUM_ZERO   = 3'd3,
        PH_NUM_DIGITS = 3'd4,
        PH_SKIP       = 3'd5,
        PH_TEXT       = 3'd6,
        PH_HALT       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC    = 2'd0,
        BASE_OCT    = 2'd1,
        BASE_HEX    = 2'd2,
        BASE_SIGNED = 2'd3
    } base_t;

    // operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ACC    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_FINISH = 3'd3,
        OP_TEXT   = 3'd4,
        OP_NEG    = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] radix_sel;
        logic [3:0] digit;
        logic [2:0] field_id;
        logic       numeric;
        logic [7:0] text_byte;
        logic       text_end;
        logic       last;
        logic       bad;
    } cmd_t;

    function automatic logic [3:0] key_len(input logic [3:0] k);
        case (k)
            4'd0: key_len = 4'd5;
            4'd1: key_len = 4'd7;
            4'd2: key_len = 4'd7;
            4'd3: key_len = 4'd5;
            4'd4: key_len = 4'd3;
            4'd5: key_len = 4'd8;
            4'd6: key_len = 4'd5;
            4'd7: key_len = 4'd4;
            4'd8: key_len = 4'd4;
            default: key_len = 4'd3;
        endcase
    endfunction

    // keyword letter at index i of key k, zero past its end
    function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] i);
        logic [63:0] s;
        logic [7:0]  c;
        begin
            case (k)
                4'd0: s = "atime";
                4'd1: s = "comment";
                4'd2: s = "charset";
                4'd3: s = "ctime";
                4'd4: s = "gid";
                4'd5: s = "linkpath";
                4'd6: s = "mtime";
                4'd7: s = "path";
                4'd8: s = "size";
                default: s = "uid";
            endcase
            if (i < key_len(k))
                c = s[8 * (key_len(k) - 4'd1 - i) +: 8];
            else
                c = 8'd0;
            key_char = c;
        end
    endfunction

    // field code, 8 for ignored keywords
    function automatic logic [3:0] key_field(input logic [3:0] k);
        case (k)
            4'd0: key_field = 4'd0;
            4'd3: key_field = 4'd1;
            4'd4: key_field = 4'd2;
            4'd5: key_field = 4'd7;
            4'd6: key_field = 4'd3;
            4'd7: key_field = 4'd6;
            4'd8: key_field = 4'd4;
            4'd9: key_field = 4'd5;
            default: key_field = 4'd8;
        endcase
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            digit_value = 5'(b - "0");
        else if (b >= "a" && b <= "f")
            digit_value = 5'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F")
            digit_value = 5'(b - "A" + 8'd10);
        else
            digit_value = 5'd31;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pehp_front.sv
// pehp_front: record framing, length parse, keyword match and number syntax, one byte per cycle while in_valid
// depends on pehp_pkg
`default_nettype none
module pehp_front
    import pehp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] header_byte,
    input  wire logic       last_byte,
    output cmd_t            cmd
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [NKEYS-1:0]       cand_reg, cand_next;
    logic [3:0]             kidx_reg, kidx_next;
    base_t                  base_reg, base_next;
    logic                   failed_reg, failed_next;
    logic [3:0]             field_reg, field_next;

    logic [4:0]             dv;
    logic                   is_sp;
    logic [LENGTH_BITS+3:0] len_mul;
    logic [3:0]             hit_field;
    logic [3:0]             hit_idx;
    logic                   hit_ok;
    logic                   ended;
    logic                   isnum;
    logic [1:0]             radix_code;

    always_comb
    begin
        dv = digit_value(header_byte);
        is_sp = header_byte == " " || (header_byte >= 8'd9 && header_byte <= 8'd13);
        len_mul = {4'd0, len_reg} * (LENGTH_BITS + 4)'(10)
                + (LENGTH_BITS + 4)'(header_byte - "0");
        hit_ok = 1'b0;
        hit_idx = 4'd0;
        for (int i = NKEYS - 1; i >= 0; i--)
        begin
            if (cand_reg[i] && key_len(4'(i)) == kidx_reg)
            begin
                hit_ok = 1'b1;
                hit_idx = 4'(i);
            end
        end
        hit_field = (hit_ok) ? key_field(hit_idx) : 4'd8;
        radix_code = (base_reg == BASE_OCT) ? 2'd1 : ((base_reg == BASE_HEX) ? 2'd2 : 2'd0);
    end

    always_comb
    begin
        phase_next = phase_reg;
        len_next = len_reg;
        pos_next = pos_reg;
        cand_next = cand_reg;
        kidx_next = kidx_reg;
        base_next = base_reg;
        failed_next = failed_reg;
        field_next = field_reg;
        ended = 1'b0;
        isnum = field_reg <= 4'd5;
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.field_id = field_reg[2:0];
        cmd.numeric = isnum;
        cmd.radix_sel = radix_code;
        case (phase_reg)
            PH_LEN:
            begin
                if (header_byte >= "0" && header_byte <= "9")
                    len_next = (len_mul > {4'd0, LEN_MAX}) ? LEN_MAX : len_mul[LENGTH_BITS-1:0];
                else if (header_byte == " " && pos_reg != '0)
                    phase_next = PH_KEY;
                else
                begin
                    failed_next = 1'b1;
                    phase_next = PH_HALT;
                end
            end
            PH_KEY:
            begin
                if (pos_reg >= len_reg)
                begin
                    failed_next = 1'b1;
                    phase_next = PH_HALT;
                end
                else if (header_byte == "=")
                begin
                    field_next = hit_field;
                    cmd.op = OP_CLEAR;
                    if (pos_reg == len_reg - 1'b1)
                    begin
                        ended = 1'b1;
                        cmd.op = OP_FINISH;
                        cmd.field_id = hit_field[2:0];
                        cmd.numeric = hit_field <= 4'd5;
                        cmd.radix_sel = 2'd0;
                    end
                    else if (hit_field <= 4'd5)
                        phase_next = PH_NUM_LEAD;
                    else if (hit_field <= 4'd7)
                        phase_next = PH_TEXT;
                    else
                        phase_next = PH_SKIP;
                end
                else
                begin
                    for (int i = 0; i < NKEYS; i++)
                    begin
                        if (kidx_reg >= key_len(4'(i)) || key_char(4'(i), kidx_reg) != header_byte)
                            cand_next[i] = 1'b0;
                    end
                    if (kidx_reg != 4'd15)
                        kidx_next = kidx_reg + 4'd1;
                end
            end
            PH_HALT:
            begin
            end
            default:
            begin
                if (pos_reg >= len_reg - 1'b1)
                begin
                    ended = 1'b1;
                    cmd.op = OP_FINISH;
                end
                else if (phase_reg == PH_TEXT)
                begin
                    cmd.op = OP_TEXT;
                    cmd.text_byte = header_byte;
                    cmd.text_end = pos_reg == len_reg - 2'd2;
                end
                else if (phase_reg == PH_NUM_LEAD)
                begin
                    if (is_sp && base_reg != BASE_SIGNED)
                    begin
                    end
                    else if ((header_byte == "+" || header_byte == "-")
                             && base_reg != BASE_SIGNED)
                    begin
                        base_next = BASE_SIGNED;
                        if (header_byte == "-")
                            cmd.op = OP_NEG;
                    end
                    else if (header_byte == "0")
                    begin
                        base_next = BASE_OCT;
                        phase_next = PH_NUM_ZERO;
                    end
                    else if (dv >= 5'd1 && dv <= 5'd9)
                    begin
                        base_next = BASE_DEC;
                        cmd.op = OP_ACC;
                        cmd.digit = dv[3:0];
                        cmd.radix_sel = 2'd0;
                        phase_next = PH_NUM_DIGITS;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                else if (phase_reg == PH_NUM_ZERO)
                begin
                    if (header_byte == "x" || header_byte == "X")
                    begin
                        base_next = BASE_HEX;
                        phase_next = PH_NUM_DIGITS;
                    end
                    else if (dv < 5'd8)
                    begin
                        cmd.op = OP_ACC;
                        cmd.digit = dv[3:0];
                        cmd.radix_sel = 2'd1;
                        phase_next = PH_NUM_DIGITS;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                else if (phase_reg == PH_NUM_DIGITS)
                begin
                    if (dv < ((base_reg == BASE_OCT) ? 5'd8 :
                              ((base_reg == BASE_HEX) ? 5'd16 : 5'd10)))
                    begin
                        cmd.op = OP_ACC;
                        cmd.digit = dv[3:0];
                    end
                    else
                        phase_next = PH_SKIP;
                end
            end
        endcase
        if (ended)
        begin
            phase_next = PH_LEN;
            len_next = '0;
            pos_next = '0;
            cand_next = '1;
            kidx_next = 4'd0;
            base_next = BASE_DEC;
            field_next = 4'd8;
        end
        else if (pos_reg != LEN_MAX)
            pos_next = pos_reg + 1'b1;
        cmd.last = last_byte;
        cmd.bad = failed_next || phase_next != PH_LEN || pos_next != '0;
        if (last_byte)
        begin
            phase_next = PH_LEN;
            len_next = '0;
            pos_next = '0;
            cand_next = '1;
            kidx_next = 4'd0;
            base_next = BASE_DEC;
            failed_next = 1'b0;
            field_next = 4'd8;
        end
        if (!in_valid)
            cmd = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            len_reg <= '0;
            pos_reg <= '0;
            cand_reg <= '1;
            kidx_reg <= 4'd0;
            base_reg <= BASE_DEC;
            failed_reg <= 1'b0;
            field_reg <= 4'd8;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            len_reg <= len_next;
            pos_reg <= pos_next;
            cand_reg <= cand_next;
            kidx_reg <= kidx_next;
            base_reg <= base_next;
            failed_reg <= failed_next;
            field_reg <= field_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && last_byte) |=> (phase_reg == PH_LEN && pos_reg == '0))
        else $error("front not reset after last byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |-> failed_reg)
        else $error("halt without failure");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TEXT) |-> (field_reg == 4'd6 || field_reg == 4'd7))
        else $error("text phase on non-text field");

endmodule
`default_nettype wire

// File: rtl/core/pehp_cmd_fifo.sv
// pehp_cmd_fifo: short command queue between front and back
// depends on pehp_pkg
`default_nettype none
module pehp_cmd_fifo
    import pehp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    cmd_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full = cnt_reg == 3'd4;
    assign empty = cnt_reg == 3'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr_en && !full)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en && !empty)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en && !full) - 3'(rd_en && !empty);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !(rd_en && !empty)) |=> full)
        else $error("full dropped without read");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg == rp_reg) |-> (cnt_reg == 3'd0 || cnt_reg == 3'd4))
        else $error("pointer and count disagree");

endmodule
`default_nettype wire

// File: rtl/core/pehp_back.sv
// pehp_back: value accumulator and result emitter, up to two items per command
// depends on pehp_pkg
`default_nettype none
module pehp_back
    import pehp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire cmd_t                  cmd,
    output logic                       cmd_take,
    output logic                       res_valid,
    input  wire logic                  res_take,
    output logic [1:0]                 kind,
    output logic [2:0]                 field_id,
    output logic [VALUE_BITS-1:0]      number,
    output logic [7:0]                 text_byte,
    output logic                       text_end
);

    localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  ovf_reg, ovf_next;
    logic                  status_reg, status_next;
    logic                  sbad_reg, sbad_next;
    logic                  ov_reg;
    logic [1:0]            okind_reg;
    logic [2:0]            ofield_reg;
    logic [VALUE_BITS-1:0] onum_reg;
    logic [7:0]            obyte_reg;
    logic                  oend_reg;

    logic [VALUE_BITS+4:0] prod;
    logic [VALUE_BITS-1:0] final_num;
    logic                  out_free;
    logic                  emit1;
    logic [1:0]            e_kind;
    logic [2:0]            e_field;
    logic [VALUE_BITS-1:0] e_num;
    logic [7:0]            e_byte;
    logic                  e_end;

    assign out_free = !ov_reg || res_take;
    assign res_valid = ov_reg;
    assign kind = okind_reg;
    assign field_id = ofield_reg;
    assign number = onum_reg;
    assign text_byte = obyte_reg;
    assign text_end = oend_reg;

    always_comb
    begin
        case (cmd.radix_sel)
            2'd1: prod = {acc_reg, 3'd0} + (VALUE_BITS + 5)'(cmd.digit);
            2'd2: prod = {acc_reg, 4'd0} + (VALUE_BITS + 5)'(cmd.digit);
            default: prod = {acc_reg, 3'd0} + {2'd0, acc_reg, 1'b0}
                          + (VALUE_BITS + 5)'(cmd.digit);
        endcase
        if (ovf_reg)
            final_num = VAL_MAX;
        else if (neg_reg)
            final_num = '0 - acc_reg;
        else
            final_num = acc_reg;
    end

    // a pending status item is sent before the next command is taken
    always_comb
    begin
        acc_next = acc_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        status_next = status_reg;
        sbad_next = sbad_reg;
        cmd_take = 1'b0;
        emit1 = 1'b0;
        e_kind = KIND_NUMBER;
        e_field = 3'd0;
        e_num = '0;
        e_byte = 8'd0;
        e_end = 1'b0;
        if (status_reg)
        begin
            if (out_free)
            begin
                emit1 = 1'b1;
                e_kind = sbad_reg ? KIND_ERROR : KIND_DONE;
                status_next = 1'b0;
            end
        end
        else if (cmd_valid && out_free)
        begin
            cmd_take = 1'b1;
            case (cmd.op)
                OP_ACC:
                begin
                    if (!ovf_reg)
                    begin
                        if (prod[VALUE_BITS+4:VALUE_BITS] != '0)
                            ovf_next = 1'b1;
                        else
                            acc_next = prod[VALUE_BITS-1:0];
                    end
                end
                OP_NEG:
                    neg_next = 1'b1;
                OP_CLEAR:
                begin
                    acc_next = '0;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                end
                OP_TEXT:
                begin
                    emit1 = 1'b1;
                    e_kind = KIND_TEXT;
                    e_field = cmd.field_id;
                    e_byte = cmd.text_byte;
                    e_end = cmd.text_end;
                end
                OP_FINISH:
                begin
                    if (cmd.numeric)
                    begin
                        emit1 = 1'b1;
                        e_kind = KIND_NUMBER;
                        e_field = cmd.field_id;
                        e_num = final_num;
                    end
                    acc_next = '0;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (cmd.last)
            begin
                acc_next = '0;
                neg_next = 1'b0;
                ovf_next = 1'b0;
                if (emit1)
                begin
                    status_next = 1'b1;
                    sbad_next = cmd.bad;
                end
                else
                begin
                    emit1 = 1'b1;
                    e_kind = cmd.bad ? KIND_ERROR : KIND_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit1)
        begin
            okind_reg <= e_kind;
            ofield_reg <= e_field;
            onum_reg <= e_num;
            obyte_reg <= e_byte;
            oend_reg <= e_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            neg_reg <= 1'b0;
            ovf_reg <= 1'b0;
            status_reg <= 1'b0;
            sbad_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            ovf_reg <= ovf_next;
            status_reg <= status_next;
            sbad_reg <= sbad_next;
            if (emit1)
                ov_reg <= 1'b1;
            else if (res_take)
                ov_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        status_reg |-> !cmd_take)
        else $error("command taken while status pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_take) |=> ov_reg)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_take) |-> !emit1)
        else $error("result overwritten");

endmodule
`default_nettype wire

// File: rtl/core/pax_extended_header_parser_unit.sv
// pax_extended_header_parser_unit: top level of the pax extended header record parser
// depends on pehp_pkg, pehp_front, pehp_cmd_fifo, pehp_back
`default_nettype none
// Takes one header byte per cycle while the queue is not full. The front parses
// lengths and matches keywords in the cycle a byte is pushed and writes one
// command into a four-entry queue; the back applies each command, with one
// constant multiply-add per digit, and registers any result item. Sustained
// rate is one byte per cycle while results are popped; a last byte that finishes
// a numeric record or carries a text byte emits two items and holds the back
// until the second is sent. Items pass the queue and the back's output register.
module pax_extended_header_parser_unit
    import pehp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            header_byte,
    input  wire logic                  last_byte,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 kind,
    output logic [2:0]                 field_id,
    output logic [VALUE_BITS-1:0]      number,
    output logic [7:0]                 text_byte,
    output logic                       text_end
);

    cmd_t fcmd, qcmd;
    logic accept, qempty, take, rvalid;

    assign accept = push && !full;
    assign empty = !rvalid;

    pehp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .header_byte(header_byte), .last_byte(last_byte), .cmd(fcmd)
    );

    pehp_cmd_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .wr_en(accept), .wr_data(fcmd), .full(full),
        .rd_en(take), .rd_data(qcmd), .empty(qempty)
    );

    pehp_back #(.VALUE_BITS(VALUE_BITS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!qempty), .cmd(qcmd), .cmd_take(take),
        .res_valid(rvalid), .res_take(pop), .kind(kind), .field_id(field_id),
        .number(number), .text_byte(text_byte), .text_end(text_end)
    );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for pax_extended_header_parser_unit
// feeds pax header byte streams, predicts every result item and checks them in order
// depends on pehp_pkg and the parser rtl
`default_nettype none
module tb_top
    import pehp_pkg::*;
();

    localparam int LBITS = 24;
    localparam logic [LBITS-1:0] LEN_MAX = '1;
    localparam logic [63:0] VAL_MAX = '1;
    localparam int NFIELD_NONE = 8;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } hdr_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  fid;
        logic [63:0] num;
        logic [7:0]  tb;
        logic        te;
    } parse_res_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [7:0] header_byte;
    logic last_byte;
    logic empty;
    logic pop;
    logic [1:0] kind;
    logic [2:0] field_id;
    logic [63:0] number;
    logic [7:0] text_byte;
    logic text_end;

    pax_extended_header_parser_unit u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .header_byte(header_byte), .last_byte(last_byte),
        .empty(empty), .pop(pop), .kind(kind), .field_id(field_id),
        .number(number), .text_byte(text_byte), .text_end(text_end)
    );

    hdr_item_t  byte_q[$];
    parse_res_t expected_q[$];
    int errors = 0;
    bit stim_done = 0;
    bit no_idle = 0;
    bit hold_rx = 0;
    bit pause_tx = 0;

    // predictor state
    phase_t        p_phase;
    logic [LBITS-1:0] p_len, p_pos;
    logic [9:0]    p_cand;
    logic [3:0]    p_kidx;
    logic [63:0]   p_acc;
    base_t         p_base;
    logic          p_neg, p_ovf, p_failed;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic string key_str(int k);
        case (k)
            0: return "atime";
            1: return "comment";
            2: return "charset";
            3: return "ctime";
            4: return "gid";
            5: return "linkpath";
            6: return "mtime";
            7: return "path";
            8: return "size";
            default: return "uid";
        endcase
    endfunction

    function automatic int fld_of(int k);
        int t[10] = '{0, 8, 8, 1, 2, 7, 3, 6, 4, 5};
        return t[k];
    endfunction

    function automatic int matched_fld();
        for (int i = 0; i < 10; i++)
            if (p_cand[i]) return fld_of(i);
        return NFIELD_NONE;
    endfunction

    function automatic int dval(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return 99;
    endfunction

    function automatic int radix_of();
        if (p_base == BASE_OCT) return 8;
        if (p_base == BASE_HEX) return 16;
        return 10;
    endfunction

    task automatic record_clear();
        p_phase = PH_LEN;
        p_len = 0;
        p_pos = 0;
        p_cand = '1;
        p_kidx = 0;
        p_acc = 0;
        p_base = BASE_DEC;
        p_neg = 0;
        p_ovf = 0;
    endtask

    task automatic add_digit(int d);
        logic [63:0] r;
        r = radix_of();
        if (p_ovf) return;
        if (p_acc > (VAL_MAX - 64'(d)) / r) p_ovf = 1;
        else p_acc = p_acc * r + 64'(d);
    endtask

    task automatic push_exp(logic [1:0] k, int f, logic [63:0] n, logic [7:0] t, logic e);
        parse_res_t r;
        r.kind = k;
        r.fid = 3'(f);
        r.num = n;
        r.tb = t;
        r.te = e;
        expected_q.push_back(r);
    endtask

    task automatic close_record();
        int f;
        logic [63:0] v;
        f = matched_fld();
        if (f <= 5) begin
            if (p_ovf) v = VAL_MAX;
            else if (p_neg) v = 64'(0) - p_acc;
            else v = p_acc;
            push_exp(KIND_NUMBER, f, v, 0, 0);
        end
        record_clear();
    endtask

    task automatic predict_header_byte(hdr_item_t it);
        logic [7:0] b;
        logic [LBITS-1:0] pos, len;
        logic [LBITS+3:0] v;
        bit ended;
        int hit, f, d;
        b = it.b;
        pos = p_pos;
        len = p_len;
        ended = 0;
        if (p_phase == PH_LEN) begin
            if (b >= "0" && b <= "9") begin
                v = len * 10 + (b - "0");
                p_len = (v > LEN_MAX) ? LEN_MAX : v[LBITS-1:0];
            end else if (b == " " && pos > 0) p_phase = PH_KEY;
            else begin
                p_failed = 1;
                p_phase = PH_HALT;
            end
        end else if (p_phase == PH_KEY) begin
            if (pos >= len) begin
                p_failed = 1;
                p_phase = PH_HALT;
            end else if (b == "=") begin
                hit = 10;
                for (int i = 0; i < 10; i++)
                    if (hit == 10 && p_cand[i] && key_str(i).len() == p_kidx) hit = i;
                p_cand = (hit < 10 && fld_of(hit) != NFIELD_NONE) ? 10'(1 << hit) : 10'd0;
                if (pos == len - 1) begin
                    close_record();
                    ended = 1;
                end else begin
                    f = matched_fld();
                    p_phase = (f <= 5) ? PH_NUM_LEAD : (f <= 7 ? PH_TEXT : PH_SKIP);
                end
            end else begin
                for (int i = 0; i < 10; i++)
                    if (p_kidx >= key_str(i).len() || key_str(i)[p_kidx] != b) p_cand[i] = 0;
                if (p_kidx < 15) p_kidx++;
            end
        end else if (p_phase != PH_HALT) begin
            d = dval(b);
            if (pos >= len - 1) begin
                close_record();
                ended = 1;
            end else if (p_phase == PH_TEXT)
                push_exp(KIND_TEXT, matched_fld(), 0, b, pos == len - 2);
            else if (p_phase == PH_NUM_LEAD) begin
                if ((b == " " || (b >= 9 && b <= 13)) && p_base != BASE_SIGNED) begin
                end else if ((b == "+" || b == "-") && p_base != BASE_SIGNED) begin
                    p_base = BASE_SIGNED;
                    p_neg = (b == "-");
                end else if (b == "0") begin
                    p_base = BASE_OCT;
                    p_phase = PH_NUM_ZERO;
                end else if (d >= 1 && d <= 9) begin
                    p_base = BASE_DEC;
                    add_digit(d);
                    p_phase = PH_NUM_DIGITS;
                end else p_phase = PH_SKIP;
            end else if (p_phase == PH_NUM_ZERO) begin
                if (b == "x" || b == "X") begin
                    p_base = BASE_HEX;
                    p_phase = PH_NUM_DIGITS;
                end else if (d < 8) begin
                    add_digit(d);
                    p_phase = PH_NUM_DIGITS;
                end else p_phase = PH_SKIP;
            end else if (p_phase == PH_NUM_DIGITS) begin
                if (d < radix_of()) add_digit(d);
                else p_phase = PH_SKIP;
            end
        end
        if (!ended && pos < LEN_MAX) p_pos = pos + 1;
        if (it.last) begin
            push_exp((p_failed || p_phase != PH_LEN || p_pos != 0) ? KIND_ERROR : KIND_DONE,
                     0, 0, 0, 0);
            record_clear();
            p_failed = 0;
        end
    endtask

    task automatic add_bytes(string s, bit close_hdr);
        hdr_item_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.b = s[i];
            it.last = close_hdr && (i == s.len() - 1);
            byte_q.push_back(it);
        end
    endtask

    // builds one well-formed record around a value
    function automatic string make_record(string key, string val);
        int body, n;
        string ls;
        body = key.len() + val.len() + 3;
        n = body + 1;
        ls.itoa(n);
        if (ls.len() + body != n) begin
            n = body + ls.len();
            ls.itoa(n);
            if (ls.len() + body != n) begin
                n++;
                ls.itoa(n);
            end
        end
        return {ls, " ", key, "=", val, "\n"};
    endfunction

    function automatic string rand_number();
        string s, t;
        int n;
        s = "";
        case ($urandom_range(0, 7))
            0: s = " ";
            1: s = "\t+";
            2: s = "-";
            3: s = "+";
            default: s = "";
        endcase
        case ($urandom_range(0, 5))
            0: begin
                s = {s, "0x"};
                n = $urandom_range(0, 18);
                for (int i = 0; i < n; i++) begin
                    t = "0123456789abcdefABCDEF";
                    s = {s, string'(t[$urandom_range(0, 21)])};
                end
            end
            1: begin
                s = {s, "0"};
                n = $urandom_range(0, 23);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 7)))};
            end
            default: begin
                n = $urandom_range(0, 22);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            end
        endcase
        if ($urandom_range(0, 5) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
    endfunction

    function automatic string rand_text(int maxn);
        string s;
        int n;
        s = "";
        n = $urandom_range(0, maxn);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
    endfunction

    task automatic add_random_header();
        int nrec, k;
        string key, val, r;
        nrec = $urandom_range(1, 4);
        for (int j = 0; j < nrec; j++) begin
            k = $urandom_range(0, 11);
            key = (k < 10) ? key_str(k) : (k == 10 ? "ati" : "uidx");
            if (k == 1 || k == 2 || k == 5 || k == 7 || k >= 10) val = rand_text(12);
            else val = rand_number();
            r = make_record(key, val);
            case ($urandom_range(0, 19))
                0: r = {"12", string'(8'($urandom_range(1, 255))), r.substr(2, r.len() - 1)};
                1: r = "99 path";
                2: r = "9 abcdefghijk";
                3: r = rand_text(6);
                default: ;
            endcase
            if (r.len() == 0) r = " ";
            add_bytes(r, j == nrec - 1);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 0;
            header_byte <= 0;
            last_byte <= 0;
        end else begin
            if (push && !full) begin
                predict_header_byte(byte_q.pop_front());
            end
            if ((push && !full) || !push) begin
                if (byte_q.size() > 0 && !pause_tx &&
                    (no_idle || $urandom_range(0, 99) >= 37)) begin
                    push <= 1;
                    header_byte <= byte_q[0].b;
                    last_byte <= byte_q[0].last;
                end else
                    push <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        parse_res_t w;
        if (!rst_n)
            pop <= 0;
        else begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected item kind", kind, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (kind != w.kind) report_mismatch("kind", kind, w.kind);
                    if (field_id != w.fid) report_mismatch("field_id", field_id, w.fid);
                    if (number != w.num) report_mismatch("number", number, w.num);
                    if (text_byte != w.tb) report_mismatch("text_byte", text_byte, w.tb);
                    if (text_end != w.te) report_mismatch("text_end", text_end, w.te);
                end
            end
            pop <= !hold_rx && (no_idle || $urandom_range(0, 99) >= 37);
        end
    end

    initial begin
        rst_n = 0;
        record_clear();
        p_failed = 0;
        add_bytes({make_record("atime", "18446744073709551615"),
                   make_record("size", "18446744073709551616"),
                   make_record("gid", "0x1F"), make_record("uid", "-017"),
                   make_record("mtime", " +0x"), make_record("ctime", ""),
                   make_record("path", "a/b"), make_record("linkpath", ""),
                   make_record("linkpath", "\377\001"),
                   make_record("comment", "hi"), make_record("charset", "x"),
                   make_record("foo", "1")}, 1);
        add_bytes("5 gid=", 1);
        add_bytes("7 abc\n", 1);
        add_bytes("x", 1);
        add_bytes(" 3", 1);
        add_bytes("3 uid=7\n", 0);
        add_bytes({make_record("path", "q"), "\200"}, 1);
        repeat (7) @(posedge clk);
        rst_n = 1;
        while (byte_q.size() > 0) @(posedge clk);
        while (byte_q.size() < 1030) add_random_header();
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
        while (byte_q.size() > 900) @(posedge clk);
        pause_tx = 1;
        while (expected_q.size() > 0 || push) @(posedge clk);
        pause_tx = 0;
        no_idle = 1;
        while (byte_q.size() > 500) @(posedge clk);
        no_idle = 0;
        while (byte_q.size() > 0 || push) @(posedge clk);
        while (expected_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[pax_extended_header_parser_unit] OK");
        else
            $display("[pax_extended_header_parser_unit] ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("[pax_extended_header_parser_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: pax_extended_header_parser_unit.f
rtl/core/pehp_pkg.sv
rtl/core/pehp_front.sv
rtl/core/pehp_cmd_fifo.sv
rtl/core/pehp_back.sv
rtl/core/pax_extended_header_parser_unit.sv
tb/tb_top.sv
